/* rtl/core/supply_watch_alarm_mode_controller_top_assert.svh */
// ---------------------------------------------------------------------------
// supply watch alarm mode controller: assertion macros
// concurrent checks that compile away when synthesis is defined
// ---------------------------------------------------------------------------
`ifndef SUPPLY_WATCH_ALARM_MODE_CONTROLLER_TOP_ASSERT_SVH
`define SUPPLY_WATCH_ALARM_MODE_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// check held at every edge once out of reset
`define SWAMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("swamc assertion failed");

// check held at every edge, reset included
`define SWAMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("swamc assertion failed");

`else

`define SWAMC_ASSERT(label, clk, rst_n, prop)
`define SWAMC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/core/swamc_pkg.sv */
// ---------------------------------------------------------------------------
// swamc_pkg
// shared types, register codes and reset values of the alarm mode controller
// ---------------------------------------------------------------------------
`default_nettype none

package swamc_pkg;

    // operating modes
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_AUTO  = 2'd2
    } t_mode;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ARM_THRESHOLD    = 3'd0,
        REG_DISARM_THRESHOLD = 3'd1,
        REG_REPLUG_WINDOW    = 3'd2,
        REG_REPLUG_NEEDED    = 3'd3,
        REG_CLICK_WINDOW     = 3'd4,
        REG_BEEP_ON          = 3'd5,
        REG_BEEP_PERIOD      = 3'd6
    } t_reg_idx;

    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 8;

    // clicks that end a triple click, and drop counter ceiling
    localparam logic [2:0] CLICKS_TO_IDLE = 3'd3;
    localparam logic [2:0] DROP_MAX       = 3'd7;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0] arm_threshold;
        logic [7:0] disarm_threshold;
        logic [7:0] replug_window_ticks;
        logic [2:0] replug_needed;
        logic [7:0] click_window_ticks;
        logic [7:0] beep_on_ticks;
        logic [7:0] beep_period_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        arm_threshold:       8'd106,
        disarm_threshold:    8'd96,
        replug_window_ticks: 8'd40,
        replug_needed:       3'd3,
        click_window_ticks:  8'd7,
        beep_on_ticks:       8'd3,
        beep_period_ticks:   8'd43
    };

    typedef struct packed {
        t_mode      mode;
        logic       window_active;
        logic [7:0] window_count;
        logic [2:0] drop_count;
        logic       was_low;
        logic [1:0] click_count;
        logic [7:0] click_timer;
        logic [7:0] beep_phase;
        logic       alert;
    } t_state;

    // idle with every sub-state cleared
    localparam t_state STATE_CLEAR = '{
        mode:          MODE_IDLE,
        window_active: 1'b0,
        window_count:  8'd0,
        drop_count:    3'd0,
        was_low:       1'b1,
        click_count:   2'd0,
        click_timer:   8'd0,
        beep_phase:    8'd0,
        alert:         1'b0
    };

    typedef struct packed {
        logic  sleep_request;
        logic  alert_on;
        t_mode mode;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/supply_watch_alarm_mode_controller_top.sv */
// path: an input transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while m_axis_tready does not stall the result register;
// state is updated in a single pass between the input register and the result register
// reset: synchronous active low; config, state and valid flags back to their defaults, mode idle
// ---------------------------------------------------------------------------
// supply_watch_alarm_mode_controller_top
// three-mode supply alarm controller with stream ports and an apb register file
// ---------------------------------------------------------------------------
`default_nettype none

`include "supply_watch_alarm_mode_controller_top_assert.svh"

module supply_watch_alarm_mode_controller_top
    import swamc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // sample stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] supply_level, [8] trigger_high, [9] click, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] mode, [2] alert_on, [3] sleep_request, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       r_in_valid;
    logic [7:0] r_supply_level;
    logic       r_trigger_high;
    logic       r_click;
    logic       out_free;
    logic       advance;
    logic       cfg_write;
    t_reg_idx   reg_idx;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ARM_THRESHOLD:    r_cfg.arm_threshold       <= pwdata[7:0];
                REG_DISARM_THRESHOLD: r_cfg.disarm_threshold    <= pwdata[7:0];
                REG_REPLUG_WINDOW:    r_cfg.replug_window_ticks <= pwdata[7:0];
                REG_REPLUG_NEEDED:    r_cfg.replug_needed       <= pwdata[2:0];
                REG_CLICK_WINDOW:     r_cfg.click_window_ticks  <= pwdata[7:0];
                REG_BEEP_ON:          r_cfg.beep_on_ticks       <= pwdata[7:0];
                REG_BEEP_PERIOD:      r_cfg.beep_period_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_ARM_THRESHOLD:    prdata = {24'd0, r_cfg.arm_threshold};
            REG_DISARM_THRESHOLD: prdata = {24'd0, r_cfg.disarm_threshold};
            REG_REPLUG_WINDOW:    prdata = {24'd0, r_cfg.replug_window_ticks};
            REG_REPLUG_NEEDED:    prdata = {29'd0, r_cfg.replug_needed};
            REG_CLICK_WINDOW:     prdata = {24'd0, r_cfg.click_window_ticks};
            REG_BEEP_ON:          prdata = {24'd0, r_cfg.beep_on_ticks};
            REG_BEEP_PERIOD:      prdata = {24'd0, r_cfg.beep_period_ticks};
            default:              prdata = '0;
        endcase
    end

    // stream handshake: result register frees as it is taken
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_supply_level <= s_axis_tdata[7:0];
            r_trigger_high <= s_axis_tdata[8];
            r_click        <= s_axis_tdata[9];
        end
    end

    // one controller tick
    swamc_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_supply_level (r_supply_level),
        .i_trigger_high (r_trigger_high),
        .i_click        (r_click),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result.sleep_request, r_result.alert_on,
                            r_result.mode};

    // checks
    `SWAMC_ASSERT(a_mode_legal, i_clk, i_rst_n, r_state.mode != 2'd3)
    `SWAMC_ASSERT(a_alert_sleep_excl, i_clk, i_rst_n, r_out_valid |-> !(r_result.alert_on && r_result.sleep_request))
    `SWAMC_ASSERT(a_advance_fills_out, i_clk, i_rst_n, advance |=> r_out_valid)
    `SWAMC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !r_in_valid && !r_out_valid)

endmodule

`default_nettype wire

/* rtl/core/swamc_step.sv */
// ---------------------------------------------------------------------------
// swamc_step
// one tick of the mode controller: next state and result from state and sample
// ---------------------------------------------------------------------------
`default_nettype none

module swamc_step
    import swamc_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic [7:0] i_supply_level,
    input  logic       i_trigger_high,
    input  logic       i_click,
    output t_state     o_state,
    output t_result    o_result
);

    logic       lvl_lt_disarm;
    logic       lvl_le_disarm;
    logic       lvl_gt_arm;
    logic       lvl_ge_arm;
    logic [7:0] window_count_inc;
    logic [2:0] drop_count_inc;
    logic [7:0] click_timer_inc;
    logic [2:0] click_count_inc;
    logic [8:0] beep_phase_inc;
    logic       beep_on;

    // threshold compares
    assign lvl_lt_disarm = i_supply_level <  i_cfg.disarm_threshold;
    assign lvl_le_disarm = i_supply_level <= i_cfg.disarm_threshold;
    assign lvl_gt_arm    = i_supply_level >  i_cfg.arm_threshold;
    assign lvl_ge_arm    = i_supply_level >= i_cfg.arm_threshold;

    // saturating counters
    assign window_count_inc = (i_state.window_count != COUNT_MAX) ?
                              i_state.window_count + 8'd1 : i_state.window_count;
    assign drop_count_inc   = (lvl_le_disarm && !i_state.was_low &&
                               i_state.drop_count != DROP_MAX) ?
                              i_state.drop_count + 3'd1 : i_state.drop_count;
    assign click_timer_inc  = (i_state.click_timer != COUNT_MAX) ?
                              i_state.click_timer + 8'd1 : i_state.click_timer;
    assign click_count_inc  = {1'b0, i_state.click_count} + 3'd1;

    // beep period
    assign beep_phase_inc = {1'b0, i_state.beep_phase} + 9'd1;
    assign beep_on        = i_state.beep_phase < i_cfg.beep_on_ticks;

    // mode decisions
    always_comb begin
        t_state n_st;
        logic   sleep;
        logic   waiting;
        logic   change;
        t_mode  target;

        n_st    = i_state;
        sleep   = 1'b0;
        waiting = 1'b0;
        change  = 1'b0;
        target  = MODE_IDLE;

        case (i_state.mode)
            MODE_ARMED: begin
                if (!i_state.window_active) begin
                    n_st.alert = !i_trigger_high;
                    if (lvl_lt_disarm) begin
                        n_st.window_active = 1'b1;
                        n_st.window_count  = 8'd0;
                        n_st.drop_count    = 3'd0;
                        n_st.was_low       = 1'b1;
                    end
                end else begin
                    n_st.window_count = window_count_inc;
                    n_st.drop_count   = drop_count_inc;
                    n_st.was_low      = lvl_le_disarm;
                    if (drop_count_inc >= i_cfg.replug_needed) begin
                        change = 1'b1;
                        target = MODE_IDLE;
                    end else if (window_count_inc >= i_cfg.replug_window_ticks) begin
                        change = 1'b1;
                        target = MODE_AUTO;
                    end
                end
            end
            MODE_AUTO: begin
                // triple click sequence
                if (i_state.click_count == 2'd0) begin
                    if (i_click) begin
                        n_st.click_count = 2'd1;
                        n_st.click_timer = 8'd0;
                        waiting          = 1'b1;
                    end
                end else begin
                    n_st.click_timer = click_timer_inc;
                    if (i_click) begin
                        n_st.click_count = click_count_inc[1:0];
                        n_st.click_timer = 8'd0;
                        waiting          = 1'b1;
                        if (click_count_inc >= CLICKS_TO_IDLE) begin
                            change = 1'b1;
                            target = MODE_IDLE;
                        end
                    end else if (click_timer_inc >= i_cfg.click_window_ticks) begin
                        n_st.click_count = 2'd0;
                        n_st.click_timer = 8'd0;
                    end else begin
                        waiting = 1'b1;
                    end
                end
                // supply check and periodic beep
                if (!change) begin
                    if (waiting) begin
                        n_st.alert = 1'b0;
                    end else if (lvl_ge_arm) begin
                        change = 1'b1;
                        target = MODE_ARMED;
                    end else begin
                        n_st.alert = beep_on;
                        sleep      = !beep_on;
                        if (beep_phase_inc >= {1'b0, i_cfg.beep_period_ticks}) begin
                            n_st.beep_phase = 8'd0;
                        end else begin
                            n_st.beep_phase = beep_phase_inc[7:0];
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused code acts as idle
                if (lvl_gt_arm) begin
                    change = 1'b1;
                    target = MODE_ARMED;
                end else begin
                    n_st.mode  = MODE_IDLE;
                    n_st.alert = 1'b0;
                    sleep      = 1'b1;
                end
            end
        endcase

        // a mode change clears all sub-state
        if (change) begin
            n_st      = STATE_CLEAR;
            n_st.mode = target;
            sleep     = 1'b0;
        end

        o_state                = n_st;
        o_result.mode          = n_st.mode;
        o_result.alert_on      = n_st.alert;
        o_result.sleep_request = sleep;
    end

endmodule

`default_nettype wire
